// File: hw/rtl/asc_pkg.sv
// ---------------------------------------------------------------------------
// asc_pkg
// Shared types, constants and arithmetic helpers for the alternating
// subsequence counter: tree geometry, max-with-count entries, datapath ops.
// ---------------------------------------------------------------------------
package asc_pkg;

  localparam int MAX_VALUES = 1024;
  localparam int LEAF_BITS  = $clog2(MAX_VALUES);
  localparam int NODES      = 2 * MAX_VALUES;
  localparam int ADDR_W     = $clog2(NODES);
  localparam int PTR_W      = ADDR_W + 1;
  localparam int VAL_W      = 11;
  localparam int LEN_W      = 11;
  localparam int CNT_W      = 30;

  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};
  localparam logic [CNT_W:0]   MODULUS = (CNT_W+1)'(1000000007);
  localparam logic [VAL_W-1:0] LIMIT_MAX = VAL_W'(MAX_VALUES);
  localparam logic [PTR_W-1:0] LEAF_BASE = PTR_W'(MAX_VALUES);

  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 128;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [CNT_W-1:0] cnt;
  } ent_t;

  localparam int ENT_W = LEN_W + CNT_W;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_CLR_INIT,
    OP_CLR_STEP,
    OP_Q_INIT,
    OP_Q_READ,
    OP_Q_SHIFT,
    OP_Q_ACC,
    OP_Q_SAVE,
    OP_U_READ,
    OP_U_LEAF,
    OP_U_SIB,
    OP_U_PAR,
    OP_BEST_RISE,
    OP_BEST_FALL,
    OP_OUT_LOAD
  } dp_op_t;

  // phase 0: rising result / rise tree update, phase 1: falling
  typedef struct packed {
    dp_op_t op;
    logic   phase;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_cmd;
    logic range_err;
    logic clr_last;
    logic q_done;
    logic q_read;
    logic at_root;
  } dp_stat_t;

  function automatic logic [CNT_W-1:0] mod_add(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= MODULUS) s = s - MODULUS;
    return s[CNT_W-1:0];
  endfunction

  function automatic ent_t merge(input ent_t a, input ent_t b);
    ent_t r;
    r = a;
    if (b.len > a.len) r = b;
    else if (b.len == a.len) r.cnt = mod_add(a.cnt, b.cnt);
    return r;
  endfunction

  // Leaves hold raw entries; inner nodes hold entries already extended by one.
  function automatic ent_t extend(input ent_t a, input logic is_leaf);
    ent_t r;
    r = a;
    if (is_leaf && a.len != '0 && a.len != LEN_MAX) r.len = a.len + LEN_W'(1);
    return r;
  endfunction

endpackage

// File: hw/rtl/asc_ctrl.sv
// ---------------------------------------------------------------------------
// asc_ctrl
// Sequencer: clearing sweep, two range queries, two leaf-to-root updates,
// running best merge and the output register handshake.
// ---------------------------------------------------------------------------
module asc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output asc_pkg::dp_cmd_t  cmd,
  input  asc_pkg::dp_stat_t stat
);
  import asc_pkg::*;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_DECIDE, S_Q_INIT, S_Q_STEP, S_Q_ACC,
    S_U_READ, S_U_LEAF, S_U_SIB, S_U_PAR, S_BEST_RISE, S_BEST_FALL, S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   phase_r, phase_nxt;
  logic   out_pend_r, out_pend_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    out_pend_nxt  = out_pend_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    cmd.op        = OP_NONE;
    cmd.phase     = phase_r;
    case (state_r)
      S_CLR: begin
        cmd.op = OP_CLR_STEP;
        if (stat.clr_last) begin
          state_nxt    = out_pend_r ? S_OUT : S_IDLE;
          out_pend_nxt = 1'b0;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat.clr_cmd) begin
          cmd.op       = OP_CLR_INIT;
          out_pend_nxt = 1'b1;
          state_nxt    = S_CLR;
        end else if (stat.range_err) begin
          state_nxt = S_OUT;
        end else begin
          phase_nxt = 1'b0;
          state_nxt = S_Q_INIT;
        end
      end
      S_Q_INIT: begin
        cmd.op    = OP_Q_INIT;
        state_nxt = S_Q_STEP;
      end
      S_Q_STEP: begin
        if (stat.q_done) begin
          cmd.op = OP_Q_SAVE;
          if (!phase_r) begin
            phase_nxt = 1'b1;
            state_nxt = S_Q_INIT;
          end else begin
            phase_nxt = 1'b0;
            state_nxt = S_U_READ;
          end
        end else if (stat.q_read) begin
          cmd.op    = OP_Q_READ;
          state_nxt = S_Q_ACC;
        end else begin
          cmd.op = OP_Q_SHIFT;
        end
      end
      S_Q_ACC: begin
        cmd.op    = OP_Q_ACC;
        state_nxt = S_Q_STEP;
      end
      S_U_READ: begin
        cmd.op    = OP_U_READ;
        state_nxt = S_U_LEAF;
      end
      S_U_LEAF: begin
        cmd.op    = OP_U_LEAF;
        state_nxt = S_U_SIB;
      end
      S_U_SIB: begin
        if (stat.at_root) begin
          if (!phase_r) begin
            phase_nxt = 1'b1;
            state_nxt = S_U_READ;
          end else begin
            phase_nxt = 1'b0;
            state_nxt = S_BEST_RISE;
          end
        end else begin
          cmd.op    = OP_U_SIB;
          state_nxt = S_U_PAR;
        end
      end
      S_U_PAR: begin
        cmd.op    = OP_U_PAR;
        state_nxt = S_U_SIB;
      end
      S_BEST_RISE: begin
        cmd.op    = OP_BEST_RISE;
        state_nxt = S_BEST_FALL;
      end
      S_BEST_FALL: begin
        cmd.op    = OP_BEST_FALL;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          cmd.op        = OP_OUT_LOAD;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      phase_r     <= 1'b0;
      out_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      out_pend_r  <= out_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: hw/rtl/asc_dpath.sv
// ---------------------------------------------------------------------------
// asc_dpath
// Two max-with-count segment trees in single-port-write memories, query
// pointers and accumulator, update walker, running best and result register.
// ---------------------------------------------------------------------------
module asc_dpath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  asc_pkg::dp_cmd_t                   cmd,
  output asc_pkg::dp_stat_t                  stat,
  input  logic                               cfg_valid,
  input  logic [asc_pkg::VAL_W-1:0]          cfg_data,
  input  logic                               in_command,
  input  logic [asc_pkg::VAL_W-1:0]          in_value,
  output logic [asc_pkg::OUT_DATA_W-1:0]     out_data,
  output logic                               out_err
);
  import asc_pkg::*;

  logic [ENT_W-1:0] rise_mem [NODES];
  logic [ENT_W-1:0] fall_mem [NODES];
  ent_t             rise_rd_r, fall_rd_r;
  logic             rd_leaf_r;

  logic [VAL_W-1:0]  limit_r;
  logic [VAL_W-1:0]  v_r;
  logic [VAL_W-1:0]  lim;
  logic              clr_cmd_r, err_r;
  logic [PTR_W-1:0]  lo_r, hi_r;
  logic [ADDR_W-1:0] node_r;
  logic [ADDR_W-1:0] clr_addr_r;
  ent_t              acc_r, cur_r, rise_r, fall_r, best_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic              out_err_r;

  logic [PTR_W-1:0]  hi_m1;
  logic [PTR_W-1:0]  leaf_ptr;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  ent_t              wr_ent, q_rd, u_rd, leaf_new, par_new;
  logic              we_rise, we_fall, upd_wr;

  always_comb begin
    lim = limit_r;
    if (limit_r == '0) lim = VAL_W'(1);
    else if (limit_r > LIMIT_MAX) lim = LIMIT_MAX;
  end

  assign hi_m1    = hi_r - PTR_W'(1);
  assign leaf_ptr = LEAF_BASE + PTR_W'(v_r) - PTR_W'(1);

  // query reads the opposite tree, update touches the tree of its phase
  assign q_rd     = cmd.phase ? rise_rd_r : fall_rd_r;
  assign u_rd     = cmd.phase ? fall_rd_r : rise_rd_r;
  assign leaf_new = merge(u_rd, cmd.phase ? fall_r : rise_r);
  assign par_new  = merge(cur_r, extend(u_rd, rd_leaf_r));

  always_comb begin
    case (cmd.op)
      OP_U_READ: rd_addr = leaf_ptr[ADDR_W-1:0];
      OP_U_SIB:  rd_addr = node_r ^ ADDR_W'(1);
      default:   rd_addr = lo_r[0] ? lo_r[ADDR_W-1:0] : hi_m1[ADDR_W-1:0];
    endcase
  end

  always_comb begin
    case (cmd.op)
      OP_U_LEAF: begin
        wr_addr = node_r;
        wr_ent  = leaf_new;
      end
      OP_U_PAR: begin
        wr_addr = node_r >> 1;
        wr_ent  = par_new;
      end
      default: begin
        wr_addr = clr_addr_r;
        wr_ent  = '0;
      end
    endcase
  end

  assign upd_wr  = (cmd.op == OP_U_LEAF) || (cmd.op == OP_U_PAR);
  assign we_rise = (cmd.op == OP_CLR_STEP) || (upd_wr && !cmd.phase);
  assign we_fall = (cmd.op == OP_CLR_STEP) || (upd_wr && cmd.phase);

  always_ff @(posedge clk) begin
    if (we_rise) rise_mem[wr_addr] <= wr_ent;
    rise_rd_r <= rise_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (we_fall) fall_mem[wr_addr] <= wr_ent;
    fall_rd_r <= fall_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    rd_leaf_r <= rd_addr[LEAF_BITS];
  end

  assign stat.clr_cmd   = clr_cmd_r;
  assign stat.range_err = err_r;
  assign stat.clr_last  = (clr_addr_r == {ADDR_W{1'b1}});
  assign stat.q_done    = (lo_r >= hi_r);
  assign stat.q_read    = lo_r[0] | hi_r[0];
  assign stat.at_root   = (node_r == ADDR_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r    <= LIMIT_MAX;
      clr_addr_r <= '0;
      best_r     <= '0;
    end else begin
      if (cfg_valid) limit_r <= cfg_data;
      case (cmd.op)
        OP_CLR_INIT: begin
          clr_addr_r <= '0;
          best_r     <= '0;
        end
        OP_CLR_STEP:  clr_addr_r <= clr_addr_r + ADDR_W'(1);
        OP_BEST_RISE: best_r <= merge(best_r, rise_r);
        OP_BEST_FALL: best_r <= merge(best_r, fall_r);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        v_r       <= in_value;
        clr_cmd_r <= in_command;
        err_r     <= !in_command && (in_value == '0 || in_value > lim);
        rise_r    <= '0;
        fall_r    <= '0;
      end
      OP_Q_INIT: begin
        acc_r <= '{len: LEN_W'(1), cnt: CNT_W'(1)};
        if (!cmd.phase) begin
          lo_r <= LEAF_BASE;
          hi_r <= LEAF_BASE + PTR_W'(v_r) - PTR_W'(1);
        end else begin
          lo_r <= LEAF_BASE + PTR_W'(v_r);
          hi_r <= LEAF_BASE + PTR_W'(lim);
        end
      end
      OP_Q_READ: begin
        if (lo_r[0]) lo_r <= lo_r + PTR_W'(1);
        else         hi_r <= hi_m1;
      end
      OP_Q_SHIFT: begin
        lo_r <= lo_r >> 1;
        hi_r <= hi_r >> 1;
      end
      OP_Q_ACC: acc_r <= merge(acc_r, extend(q_rd, rd_leaf_r));
      OP_Q_SAVE: begin
        if (cmd.phase) fall_r <= acc_r;
        else           rise_r <= acc_r;
      end
      OP_U_READ: node_r <= leaf_ptr[ADDR_W-1:0];
      OP_U_LEAF: cur_r  <= extend(leaf_new, 1'b1);
      OP_U_PAR: begin
        cur_r  <= par_new;
        node_r <= node_r >> 1;
      end
      OP_OUT_LOAD: begin
        out_data_r <= {5'd0, best_r.cnt, best_r.len, fall_r.cnt, fall_r.len,
                       rise_r.cnt, rise_r.len};
        out_err_r  <= err_r;
      end
      default: ;
    endcase
  end

  assign out_data = out_data_r;
  assign out_err  = out_err_r;

endmodule

// File: hw/rtl/alternating_subsequence_counter.sv
// ---------------------------------------------------------------------------
// alternating_subsequence_counter
// Longest strictly alternating subsequence length and count (mod 1e9+7)
// per pushed value, using two max-with-count segment trees over the values.
// ---------------------------------------------------------------------------
//  channel | dir | ports                         | contents
//  in_     | in  | tvalid/tready/tdata/tuser     | one request: command, value
//  out_    | out | tvalid/tready/tdata/tuser     | one result per request
//  cfg_    | in  | valid/ready/data              | value_limit write
//
//  A push takes two range queries (up to two node reads per tree level, each
//  read followed by a merge, then a level shift) and two leaf-to-root updates
//  (a sibling read and a parent write per level); all reads use the single
//  read port of each tree memory. An out-of-range value skips queries and
//  updates. After reset and after a clear request, a sweep zeroes both
//  trees; no request is taken during it, configuration writes are.
//  The result sits in an output register, so a stalled result holds only
//  the final hand-off; the next request is taken once the result is loaded.
// ---------------------------------------------------------------------------
module alternating_subsequence_counter (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [asc_pkg::IN_DATA_W-1:0]      in_tdata,  // [10:0] value
  input  logic [0:0]                         in_tuser,  // [0] command
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [10:0] rise_length, [40:11] rise_count, [51:41] fall_length,
  // [81:52] fall_count, [92:82] best_length, [122:93] best_count
  output logic [asc_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic [0:0]                         out_tuser, // [0] range_error
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [asc_pkg::VAL_W-1:0]          cfg_data
);
  import asc_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // always take configuration; the user must change it only between requests, unenforced
  assign cfg_ready = 1'b1;

  asc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .stat       (stat)
  );

  asc_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .in_command (in_tuser[0]),
    .in_value   (in_tdata[VAL_W-1:0]),
    .out_data   (out_tdata),
    .out_err    (out_tuser[0])
  );

endmodule

// File: tb/alternating_subsequence_counter_test.sv
// ---------------------------------------------------------------------------
// alternating_subsequence_counter_test
// Self-checking bench for the alternating subsequence counter. Pushes
// directed and random value streams and clear requests, and rewrites the
// value limit between phases. A local max-with-count predictor supplies the
// expected result of every request, and each result is compared field by
// field in arrival order. Sender gaps and receiver stalls vary by phase.
// ---------------------------------------------------------------------------
module alternating_subsequence_counter_test;
  import asc_pkg::*;

  localparam logic CMD_PUSH  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;
  localparam int   WATCHDOG_LIMIT = 40000;
  localparam logic [CNT_W:0] PRIME = 31'd1000000007;

  typedef struct packed {
    logic [LEN_W-1:0] rise_len;
    logic [CNT_W-1:0] rise_cnt;
    logic [LEN_W-1:0] fall_len;
    logic [CNT_W-1:0] fall_cnt;
    logic [LEN_W-1:0] best_len;
    logic [CNT_W-1:0] best_cnt;
    logic             range_err;
  } result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;   // [10:0] value
  logic [0:0] in_tuser = '0;             // [0] command
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;      // rise/fall/best length and count
  logic [0:0] out_tuser;                 // [0] range_error
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [VAL_W-1:0] cfg_data = '0;

  // predictor state: per-value best length/count for each ending direction
  logic [LEN_W-1:0] rise_len_tab [1:MAX_VALUES];
  logic [CNT_W-1:0] rise_cnt_tab [1:MAX_VALUES];
  logic [LEN_W-1:0] fall_len_tab [1:MAX_VALUES];
  logic [CNT_W-1:0] fall_cnt_tab [1:MAX_VALUES];
  logic [LEN_W-1:0] top_len;
  logic [CNT_W-1:0] top_cnt;
  logic [VAL_W-1:0] limit_reg;

  result_t expected_results[$];
  int mismatches = 0;
  int quiet_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  alternating_subsequence_counter dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic logic [CNT_W-1:0] add_mod(logic [CNT_W-1:0] a, logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= PRIME) s = s - PRIME;
    return s[CNT_W-1:0];
  endfunction

  // Max-with-count fold of one candidate into a running pair.
  task automatic fold(inout logic [LEN_W-1:0] bl, inout logic [CNT_W-1:0] bc,
                      input logic [LEN_W-1:0] l, input logic [CNT_W-1:0] c);
    if (l > bl) begin
      bl = l;
      bc = c;
    end else if (l == bl) begin
      bc = add_mod(bc, c);
    end
  endtask

  task automatic clear_tables();
    for (int u = 1; u <= MAX_VALUES; u++) begin
      rise_len_tab[u] = '0; rise_cnt_tab[u] = '0;
      fall_len_tab[u] = '0; fall_cnt_tab[u] = '0;
    end
    top_len = '0;
    top_cnt = '0;
  endtask

  // Work out the result of one request and advance the predictor state.
  task automatic predict_step(input logic cmd, input logic [VAL_W-1:0] v,
                              output result_t r);
    int lim;
    logic [LEN_W-1:0] l;
    r = '0;
    lim = int'(limit_reg);
    if (lim < 1) lim = 1;
    if (lim > MAX_VALUES) lim = MAX_VALUES;
    if (cmd == CMD_CLEAR) begin
      clear_tables();
      return;
    end
    if (v < 1 || v > lim) begin
      r.range_err = 1'b1;
      r.best_len = top_len;
      r.best_cnt = top_cnt;
      return;
    end
    r.rise_len = LEN_W'(1); r.rise_cnt = CNT_W'(1);
    r.fall_len = LEN_W'(1); r.fall_cnt = CNT_W'(1);
    // rising step: extend falling-ended runs on smaller values
    for (int u = 1; u < v; u++) begin
      if (fall_len_tab[u] != 0) begin
        l = (fall_len_tab[u] == LEN_MAX) ? LEN_MAX : fall_len_tab[u] + LEN_W'(1);
        fold(r.rise_len, r.rise_cnt, l, fall_cnt_tab[u]);
      end
    end
    // falling step: extend rising-ended runs on larger values
    for (int u = v + 1; u <= lim; u++) begin
      if (rise_len_tab[u] != 0) begin
        l = (rise_len_tab[u] == LEN_MAX) ? LEN_MAX : rise_len_tab[u] + LEN_W'(1);
        fold(r.fall_len, r.fall_cnt, l, rise_cnt_tab[u]);
      end
    end
    fold(rise_len_tab[v], rise_cnt_tab[v], r.rise_len, r.rise_cnt);
    fold(fall_len_tab[v], fall_cnt_tab[v], r.fall_len, r.fall_cnt);
    fold(top_len, top_cnt, r.rise_len, r.rise_cnt);
    fold(top_len, top_cnt, r.fall_len, r.fall_cnt);
    r.best_len = top_len;
    r.best_cnt = top_cnt;
  endtask

  // Receiver: stall at the rate the current phase asks.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.rise_len  = out_tdata[10:0];
      got.rise_cnt  = out_tdata[40:11];
      got.fall_len  = out_tdata[51:41];
      got.fall_cnt  = out_tdata[81:52];
      got.best_len  = out_tdata[92:82];
      got.best_cnt  = out_tdata[122:93];
      got.range_err = out_tuser[0];
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  // Watchdog: end the run after a long stretch with no handshake at all.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Send one request, with an optional idle gap ahead of it; valid stays
  // high afterwards, so back-to-back requests keep valid asserted between them.
  task automatic send_request(input logic cmd, input logic [VAL_W-1:0] v);
    result_t r;
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {{(IN_DATA_W-VAL_W){1'b0}}, v};
    do @(posedge clk); while (!in_tready);
    predict_step(cmd, v, r);
    expected_results.push_back(r);
  endtask

  // Drop valid, then hold until every expected result is back.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_limit(input logic [VAL_W-1:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    limit_reg = v;
  endtask

  // Field extremes, clear, out-of-range values and small limits.
  task automatic test_directed();
    send_request(CMD_PUSH, 11'd1);
    send_request(CMD_PUSH, 11'd1024);
    send_request(CMD_PUSH, 11'd3);
    send_request(CMD_PUSH, 11'd5);
    send_request(CMD_PUSH, 11'd2);
    send_request(CMD_PUSH, 11'd0);
    send_request(CMD_PUSH, 11'd1025);
    send_request(CMD_PUSH, 11'd2047);
    send_request(CMD_PUSH, 11'd4);
    send_request(CMD_CLEAR, 11'd2047);
    send_request(CMD_PUSH, 11'd7);
    send_request(CMD_PUSH, 11'd7);
    send_request(CMD_PUSH, 11'd6);
    write_limit(11'd5);          // entries above 5 drop out of queries
    send_request(CMD_PUSH, 11'd6);
    send_request(CMD_PUSH, 11'd5);
    send_request(CMD_PUSH, 11'd4);
    write_limit(11'd1024);       // and come back again
    send_request(CMD_PUSH, 11'd3);
  endtask

  // Register out of range: zero acts as one, all ones as the maximum.
  task automatic test_limit_extremes();
    write_limit(11'd0);
    send_request(CMD_PUSH, 11'd1);
    send_request(CMD_PUSH, 11'd2);
    send_request(CMD_PUSH, 11'd1);
    write_limit(11'd2047);
    send_request(CMD_PUSH, 11'd1024);
    send_request(CMD_PUSH, 11'd1025);
    send_request(CMD_PUSH, 11'd512);
    write_limit(11'd1);
    send_request(CMD_PUSH, 11'd1);
    send_request(CMD_PUSH, 11'd1);
  endtask

  // Mostly in-range pushes under the given limit (small limits let long runs
  // build up), plus some out-of-range values and rare clears.
  task automatic test_random_phase(input int n, input int idle_pct, input int stall_pct,
                                   input logic [VAL_W-1:0] lim);
    int pick, eff;
    logic [VAL_W-1:0] v;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    write_limit(lim);
    eff = (lim == 0) ? 1 : (lim > MAX_VALUES) ? MAX_VALUES : lim;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 1) begin
        send_request(CMD_CLEAR, VAL_W'($urandom));
      end else if (pick < 6) begin
        v = ($urandom_range(1) != 0) ? VAL_W'(0) : VAL_W'($urandom_range(2047, eff + 1));
        send_request(CMD_PUSH, v);
      end else begin
        send_request(CMD_PUSH, VAL_W'($urandom_range(eff, 1)));
      end
    end
  endtask

  initial begin
    limit_reg = VAL_W'(MAX_VALUES);
    clear_tables();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_limit_extremes();
    test_random_phase(150, 0, 0, 11'd12);
    test_random_phase(250, 49, 0, 11'd40);
    test_random_phase(250, 0, 49, 11'd8);
    test_random_phase(250, 13, 13, 11'd1024);
    test_random_phase(150, 0, 0, 11'd300);
    drain();
    repeat (200) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
